// ===== rtl/fqsu_pkg.sv =====
// fqsu_pkg: shared types and constants for the fifo queue with search and update
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package fqsu_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;

  // input stream data: value then position, padded to whole bytes
  localparam int IN_DW = ((VALUE_W + POS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_UPDATE  = 2'd2,
    OP_SEARCH  = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 2'd0,
    ST_EMPTY        = 2'd1,
    ST_FULL         = 2'd2,
    ST_BAD_POSITION = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDWAIT,
    S_SCAN,
    S_RESP
  } fsm_t;

endpackage

// ===== rtl/fqsu_ram.sv =====
// fqsu_ram: entry storage, one write port and one read port with registered read data
// depends on fqsu_pkg for the entry width
`timescale 1ns / 1ps

module fqsu_ram #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr,
  input  logic [fqsu_pkg::VALUE_W-1:0]        wr_data,
  input  logic                                rd_en,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr,
  output logic [fqsu_pkg::VALUE_W-1:0]        rd_data
);
  import fqsu_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/fqsu_ctrl.sv =====
// fqsu_ctrl: ring pointers, operation sequencer and result register
// depends on fqsu_pkg; drives the ports of fqsu_ram
`timescale 1ns / 1ps

module fqsu_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fqsu_pkg::OP_W-1:0]           in_op,
  input  logic [fqsu_pkg::VALUE_W-1:0]        in_value,
  input  logic [fqsu_pkg::POS_W-1:0]          in_pos,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fqsu_pkg::ST_W-1:0]           out_status,
  output logic                                out_found,
  output logic [fqsu_pkg::VALUE_W-1:0]        out_removed,
  output logic [$clog2(DEPTH+1)-1:0]          out_occ,
  output logic                                wr_en,
  output logic [$clog2(DEPTH)-1:0]            wr_addr,
  output logic [fqsu_pkg::VALUE_W-1:0]        wr_data,
  output logic                                rd_en,
  output logic [$clog2(DEPTH)-1:0]            rd_addr,
  input  logic [fqsu_pkg::VALUE_W-1:0]        rd_data
);
  import fqsu_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    logic [AW-1:0] r;
    if (s == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  fsm_t               state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [AW-1:0]      scan_slot_r, scan_slot_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  status_t            res_status_r, res_status_nxt;
  logic               res_found_r, res_found_nxt;
  logic [VALUE_W-1:0] res_removed_r, res_removed_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic               out_found_r, out_found_nxt;
  logic [VALUE_W-1:0] out_removed_r, out_removed_nxt;
  logic [CNT_W-1:0]   out_occ_r, out_occ_nxt;

  logic [SUM_W-1:0]   upd_sum;
  logic [AW-1:0]      upd_slot;
  logic               pos_ok;
  logic [CNT_W-1:0]   scan_next_idx;

  // position counted from the head, wrapped once (position below count keeps it under 2x)
  always_comb begin
    upd_sum = SUM_W'(head_r) + SUM_W'(in_pos);
    if (upd_sum >= SUM_W'(DEPTH)) begin
      upd_sum = upd_sum - SUM_W'(DEPTH);
    end
    upd_slot = upd_sum[AW-1:0];
  end

  assign pos_ok        = CMP_W'(in_pos) < CMP_W'(count_r);
  assign scan_next_idx = scan_idx_r + 1'b1;

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    scan_slot_nxt   = scan_slot_r;
    scan_idx_nxt    = scan_idx_r;
    value_nxt       = value_r;
    res_status_nxt  = res_status_r;
    res_found_nxt   = res_found_r;
    res_removed_nxt = res_removed_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_found_nxt   = out_found_r;
    out_removed_nxt = out_removed_r;
    out_occ_nxt     = out_occ_r;
    in_ready        = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = tail_r;
    wr_data         = in_value;
    rd_en           = 1'b0;
    rd_addr         = head_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          value_nxt       = in_value;
          res_status_nxt  = ST_OK;
          res_found_nxt   = 1'b0;
          res_removed_nxt = '0;
          state_nxt       = S_RESP;
          unique case (op_t'(in_op))
            OP_ENQUEUE: begin
              if (count_r == CNT_W'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = tail_r;
                tail_nxt  = slot_inc(tail_r);
                count_nxt = count_r + 1'b1;
              end
            end
            OP_DEQUEUE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                state_nxt = S_RDWAIT;
              end
            end
            OP_UPDATE: begin
              if (!pos_ok) begin
                res_status_nxt = ST_BAD_POSITION;
              end else begin
                wr_en   = 1'b1;
                wr_addr = upd_slot;
              end
            end
            OP_SEARCH: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                rd_en         = 1'b1;
                rd_addr       = head_r;
                scan_slot_nxt = head_r;
                scan_idx_nxt  = '0;
                state_nxt     = S_SCAN;
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end

      S_RDWAIT: begin
        res_removed_nxt = rd_data;
        head_nxt        = slot_inc(head_r);
        count_nxt       = count_r - 1'b1;
        state_nxt       = S_RESP;
      end

      S_SCAN: begin
        // rd_data holds the entry at scan_idx_r; the next slot is fetched meanwhile
        if (rd_data == value_r) begin
          res_found_nxt = 1'b1;
          state_nxt     = S_RESP;
        end else if (scan_next_idx == count_r) begin
          state_nxt = S_RESP;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = slot_inc(scan_slot_r);
          scan_slot_nxt = slot_inc(scan_slot_r);
          scan_idx_nxt  = scan_next_idx;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_found_nxt   = res_found_r;
          out_removed_nxt = res_removed_r;
          out_occ_nxt     = count_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_slot_r   <= scan_slot_nxt;
    scan_idx_r    <= scan_idx_nxt;
    value_r       <= value_nxt;
    res_status_r  <= res_status_nxt;
    res_found_r   <= res_found_nxt;
    res_removed_r <= res_removed_nxt;
    out_status_r  <= out_status_nxt;
    out_found_r   <= out_found_nxt;
    out_removed_r <= out_removed_nxt;
    out_occ_r     <= out_occ_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_found   = out_found_r;
  assign out_removed = out_removed_r;
  assign out_occ     = out_occ_r;

endmodule

// ===== rtl/fifo_queue_with_search_update.sv =====
// fifo_queue_with_search_update: top level of the bounded queue with search and update
// depends on fqsu_pkg, fqsu_ram and fqsu_ctrl
`timescale 1ns / 1ps

// bounded first-in first-out queue of signed 32-bit values in a ring of DEPTH
// slots held in a single-port-read ram. each input transaction is one operation,
// selected by in_tuser: enqueue, dequeue, overwrite at a position from the head,
// or search the held entries for a value, stopping at the first match. every
// operation returns exactly one result transaction carrying status, found flag,
// removed value and occupancy. one operation is worked at a time: enqueue, update
// and any rejected operation go straight to the result state, a dequeue first
// waits for its ram read, and a search examines one entry per cycle, as the ram
// read port delivers them, until a match or the last held entry. the finished
// result waits in an output register, so a new transaction is taken while the
// previous result is still unread; the block only holds off when a second result
// is ready before the first is taken. the entry ram needs no initialization pass after reset.

module fifo_queue_with_search_update #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] value, [35:32] position, upper bits zero
  input  logic [fqsu_pkg::IN_DW-1:0]          in_tdata,
  // [1:0] operation
  input  logic [fqsu_pkg::OP_W-1:0]           in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] found, [32:1] removed_value, then occupancy, upper bits zero
  output logic [((1 + fqsu_pkg::VALUE_W + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] out_tdata,
  // [1:0] status
  output logic [fqsu_pkg::ST_W-1:0]           out_tuser
);
  import fqsu_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [VALUE_W-1:0] res_removed;
  logic               res_found;
  logic [CNT_W-1:0]   res_occ;

  // ram port wiring
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data;

  fqsu_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_value   (in_tdata[VALUE_W-1:0]),
    .in_pos     (in_tdata[VALUE_W +: POS_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_found  (res_found),
    .out_removed(res_removed),
    .out_occ    (res_occ),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  fqsu_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // pack the result fields, lowest first, zero padding on top
  always_comb begin
    out_tdata                       = '0;
    out_tdata[0]                    = res_found;
    out_tdata[1 +: VALUE_W]         = res_removed;
    out_tdata[1 + VALUE_W +: CNT_W] = res_occ;
  end

  // one operation at a time: the input is closed in the cycle after an accepted transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an operation was in progress");

  // a full rejection only happens with every slot held
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_FULL) |-> (res_occ == CNT_W'(DEPTH)))
    else $error("full status with occupancy below depth");

  // an empty rejection only happens with nothing held
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_EMPTY) |-> (res_occ == '0 && !res_found))
    else $error("empty status with entries held or found set");

  // occupancy never exceeds the ring size
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_occ <= CNT_W'(DEPTH)))
    else $error("occupancy beyond depth");

endmodule

// ===== dv/tb_fifo_queue_with_search_update.sv =====
// tb_fifo_queue_with_search_update: self-checking testbench for the queue with search and update
// depends on fqsu_pkg and fifo_queue_with_search_update; mirrors the ring and checks each result
`timescale 1ns / 1ps

module tb_fifo_queue_with_search_update;
  import fqsu_pkg::*;

  localparam int DEPTH      = 16;
  localparam int OCC_W      = $clog2(DEPTH + 1);
  localparam int OUT_DW     = ((1 + VALUE_W + OCC_W + 7) / 8) * 8;
  localparam int RANDOM_OPS = 800;
  localparam int IDLE_PCT   = 8;

  // one expected result transaction
  typedef struct packed {
    status_t            status;
    logic               found;
    logic [VALUE_W-1:0] removed;
    logic [OCC_W-1:0]   occupancy;
  } queue_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata;
  logic [OP_W-1:0]     in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;
  logic [ST_W-1:0]     out_tuser;

  // mirror of the ring held by the block
  logic [VALUE_W-1:0]  ring_mem [DEPTH];
  int unsigned         ring_head;
  int unsigned         ring_tail;
  int unsigned         ring_count;

  // results still owed by the block, oldest first
  queue_result_t       pending_results[$];

  int unsigned         error_count;
  int unsigned         results_checked;
  int unsigned         op_seen [4];
  int unsigned         status_seen [4];
  int unsigned         search_hits;

  // when set, the matching side never idles
  bit                  sender_quiet;
  bit                  receiver_quiet;

  fifo_queue_with_search_update #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one operation to the mirrored ring and return the result it owes
  function automatic queue_result_t ring_apply_op(op_t op, logic [VALUE_W-1:0] val,
                                                  logic [POS_W-1:0] pos);
    queue_result_t r;
    int unsigned   i;
    r.status  = ST_OK;
    r.found   = 1'b0;
    r.removed = '0;
    case (op)
      OP_ENQUEUE: begin
        if (ring_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_mem[ring_tail] = val;
          ring_tail = (ring_tail + 1) % DEPTH;
          ring_count++;
        end
      end
      OP_DEQUEUE: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed = ring_mem[ring_head];
          ring_head = (ring_head + 1) % DEPTH;
          ring_count--;
        end
      end
      OP_UPDATE: begin
        // position must name a held entry, which also rejects any empty queue
        if (pos >= ring_count) begin
          r.status = ST_BAD_POSITION;
        end else begin
          ring_mem[(ring_head + pos) % DEPTH] = val;
        end
      end
      default: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (i = 0; i < ring_count; i++) begin
            if (ring_mem[(ring_head + i) % DEPTH] == val) r.found = 1'b1;
          end
        end
      end
    endcase
    r.occupancy = OCC_W'(ring_count);
    return r;
  endfunction

  // drive one operation transaction; called and returning at a falling edge
  task automatic send_op(op_t op, logic [VALUE_W-1:0] val, logic [POS_W-1:0] pos);
    while (!sender_quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DW - VALUE_W - POS_W){1'b0}}, pos, val};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // accepted at this edge: predict right away so the ring mirror stays in order
    pending_results.push_back(ring_apply_op(op, val, pos));
    op_seen[op]++;
    @(negedge clk);
  endtask

  task automatic check_field(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %h, actual %h", $time, field, want, got);
      error_count++;
    end
  endtask

  // result sink: random stalls, changed at the falling edge
  always @(negedge clk) begin
    out_tready <= receiver_quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // every accepted result transaction is compared with the oldest expectation
  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: status %0d, data %h", $time, out_tuser, out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", VALUE_W'(want.status), VALUE_W'(out_tuser));
        check_field("found", VALUE_W'(want.found), VALUE_W'(out_tdata[0]));
        check_field("removed_value", want.removed, out_tdata[VALUE_W:1]);
        check_field("occupancy", VALUE_W'(want.occupancy),
                    VALUE_W'(out_tdata[VALUE_W+1 +: OCC_W]));
        status_seen[want.status]++;
        if (want.found) search_hits++;
        results_checked++;
      end
    end
  end

  // dequeue, search and update against an empty queue
  task automatic test_empty_queue();
    send_op(OP_DEQUEUE, 32'h0000_0000, 4'd0);
    send_op(OP_SEARCH, 32'h0000_0000, 4'd0);
    send_op(OP_UPDATE, 32'hDEAD_BEEF, 4'd0);
  endtask

  // fill to the brim, the first entries with extreme values, then one enqueue too many
  task automatic test_fill_to_full();
    logic [VALUE_W-1:0] fill_val;
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       fill_val = 32'h8000_0000;
        1:       fill_val = 32'h7FFF_FFFF;
        2:       fill_val = 32'h0000_0000;
        3:       fill_val = 32'hFFFF_FFFF;
        4:       fill_val = 32'h5555_5555;
        5:       fill_val = 32'hAAAA_AAAA;
        default: fill_val = 32'h0000_0100 + i;
      endcase
      send_op(OP_ENQUEUE, fill_val, 4'(i));
    end
    send_op(OP_ENQUEUE, 32'h0000_0001, 4'd0);
  endtask

  // edits and lookups at the far end of a full ring, then a dequeue and an out of range update
  task automatic test_full_queue_edits();
    send_op(OP_UPDATE, 32'h1234_5678, 4'd15);
    send_op(OP_SEARCH, 32'h1234_5678, 4'd0);
    send_op(OP_SEARCH, 32'h0BAD_CAFE, 4'd9);
    send_op(OP_DEQUEUE, 32'h0000_0000, 4'd0);
    send_op(OP_UPDATE, 32'h0F0F_0F0F, 4'd15);
  endtask

  // random mix that swings between filling and draining so both ends are hit often
  task automatic test_random_mix(int unsigned n_ops);
    bit                 filling;
    int unsigned        roll;
    op_t                op;
    logic [VALUE_W-1:0] val;
    logic [POS_W-1:0]   pos;
    filling = 1'b1;
    for (int unsigned k = 0; k < n_ops; k++) begin
      if ($urandom_range(59) == 0) filling = !filling;
      // one long stretch with no idling on either side
      sender_quiet   = (k >= 300 && k < 450);
      receiver_quiet = sender_quiet;
      roll = $urandom_range(99);
      if (roll < (filling ? 45 : 15))      op = OP_ENQUEUE;
      else if (roll < 60)                  op = OP_DEQUEUE;
      else if (roll < 80)                  op = OP_UPDATE;
      else                                 op = OP_SEARCH;
      // small pool for repeats, corner values, otherwise fully random
      roll = $urandom_range(9);
      if (roll < 3)       val = 32'($urandom_range(7));
      else if (roll == 3) val = ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else                val = $urandom;
      pos = 4'($urandom_range(DEPTH - 1));
      if (op == OP_UPDATE && ring_count != 0 && $urandom_range(9) < 8) begin
        pos = 4'($urandom_range(ring_count - 1));
      end
      if (op == OP_SEARCH && ring_count != 0 && $urandom_range(9) < 6) begin
        val = ring_mem[(ring_head + $urandom_range(ring_count - 1)) % DEPTH];
      end
      send_op(op, val, pos);
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  initial begin
    int unsigned wait_cycles;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = OP_ENQUEUE;
    out_tready     = 1'b0;
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    ring_head      = 0;
    ring_tail      = 0;
    ring_count     = 0;
    error_count    = 0;
    results_checked = 0;
    search_hits    = 0;
    for (int i = 0; i < 4; i++) begin
      op_seen[i]     = 0;
      status_seen[i] = 0;
    end
    for (int i = 0; i < DEPTH; i++) ring_mem[i] = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_queue();
    test_fill_to_full();
    test_full_queue_edits();
    test_random_mix(RANDOM_OPS);
    in_tvalid <= 1'b0;

    // wait for the last results, bounded, then keep watching for anything stray
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DEPTH + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, pending_results.size());
      error_count++;
    end

    $display("covered %0d enqueue, %0d dequeue, %0d update, %0d search transactions",
             op_seen[OP_ENQUEUE], op_seen[OP_DEQUEUE], op_seen[OP_UPDATE], op_seen[OP_SEARCH]);
    $display("checked %0d results: %0d ok, %0d empty, %0d full, %0d bad position, %0d hits",
             results_checked, status_seen[ST_OK], status_seen[ST_EMPTY],
             status_seen[ST_FULL], status_seen[ST_BAD_POSITION], search_hits);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // overall time limit, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
    $display("FAIL");
    $finish;
  end

endmodule
